### design/expression_tokenizer_core_macros.svh
// assertion macros for the expression tokenizer checker
// no dependencies
`ifndef EXPRESSION_TOKENIZER_CORE_MACROS_SVH
`define EXPRESSION_TOKENIZER_CORE_MACROS_SVH
`define ETK_ASSERT_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error("lbl");
`define ETK_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("lbl");
`endif

### design/etk_pkg.sv
// shared types and constants for the expression tokenizer
// no dependencies
`timescale 1ns / 1ps
package etk_pkg;
    localparam int MaxLabelChars = 32;
    localparam int MaxFracDigits = 18;
    localparam int LenW = $clog2(MaxLabelChars + 1);
    localparam int IdxW = $clog2(MaxLabelChars);
    localparam logic [15:0] ExpMax = 16'hFFFF;

    typedef enum logic [4:0] {
        K_LCHAR = 5'd0, K_FRAME = 5'd1, K_INT = 5'd2, K_REAL = 5'd3, K_SET = 5'd4,
        K_ADD = 5'd5, K_SUB = 5'd6, K_MUL = 5'd7, K_POW = 5'd8, K_DIV = 5'd9,
        K_PARA = 5'd10, K_DOT = 5'd11, K_SEMI = 5'd12, K_LPAR = 5'd13,
        K_RPAR = 5'd14, K_LBRC = 5'd15, K_RBRC = 5'd16, K_NL = 5'd17,
        K_UNK = 5'd18, K_END = 5'd19
    } kind_t;

    typedef enum logic [2:0] {
        M_IDLE, M_LABEL, M_INT, M_FRAC, M_EXP, M_STAR, M_SLASH
    } mode_t;

    typedef enum logic [2:0] {
        S_IN, S_FLUSH, S_TAIL, S_OUT
    } state_t;

    // character classes from the datapath
    typedef struct packed {
        logic digit;
        logic alpha;
        logic dot;
        logic e;
        logic star;
        logic slash;
        logic zero;
        logic skip;
        logic keyword;
        logic label_done;
    } stat_t;

    // commands to the datapath
    typedef struct packed {
        logic    take;      // capture input char
        logic    absorb;    // extend pending token in mode
        mode_t   mode;
        logic    start;     // begin new token from held char
        logic    clear;
        logic    lbl_first; // reset label read pointer
        logic    lbl_step;
        logic    load_out;
        kind_t   kind;
        logic    use_acc;   // output fields from accumulators
        logic    use_char;  // output char from held char
        logic    use_lbl;
        logic    last;
    } cmd_t;

    function automatic kind_t single_kind(input logic [20:0] c);
        unique case (c)
            21'h3D: single_kind = K_SET;
            21'h2B: single_kind = K_ADD;
            21'h2D: single_kind = K_SUB;
            21'h2E: single_kind = K_DOT;
            21'h3B: single_kind = K_SEMI;
            21'h28: single_kind = K_LPAR;
            21'h29: single_kind = K_RPAR;
            21'h7B: single_kind = K_LBRC;
            21'h7D: single_kind = K_RBRC;
            21'h0A: single_kind = K_NL;
            default: single_kind = K_UNK;
        endcase
    endfunction
endpackage

### design/expression_tokenizer_core.sv
// top level of the expression tokenizer: controller, classifier and datapath
// depends on etk_pkg, etk_ctrl, etk_kindsel, etk_datapath
`timescale 1ns / 1ps
//  channel | ports               | direction
//  input   | s_valid s_ready s_ch | in, one character per transaction
//  result  | m_valid m_ready m_*  | out, one token per transaction
// a character steps through capture, absorb or flush, tail and output
// a label flush primes one memory read, then emits one token per buffered character
// the label buffer is a 32-entry memory with one write and one registered read
// reset clears mode, accumulators and handshake state
// a stall on m_ready holds the controller in flush or tail and keeps s_ready low
module expression_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [20:0] s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_kind,
    output logic [20:0] m_char_code,
    output logic [31:0] m_int_value,
    output logic [59:0] m_frac_digits,
    output logic [4:0]  m_frac_count,
    output logic [15:0] m_exponent,
    output logic        m_overflow,
    output logic        m_last
);
    import etk_pkg::*;

    stat_t stat;
    cmd_t  cmd_raw, cmd;
    logic [20:0] held;
    logic [20:0] ch_q;

    // controller sequences absorb, flush and tail transactions
    etk_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .stat, .cmd(cmd_raw)
    );

    // single-char token lookup on the captured character
    assign held = s_ch;
    etk_kindsel u_kind (.ch(ch_q), .cmd_in(cmd_raw), .cmd_out(cmd));

    always_ff @(posedge aclk) begin
        if (cmd_raw.take) ch_q <= held;
    end

    etk_datapath u_dp (
        .aclk, .aresetn, .s_ch, .cmd, .stat,
        .m_kind, .m_char_code, .m_int_value, .m_frac_digits, .m_frac_count,
        .m_exponent, .m_overflow, .m_last
    );
endmodule

### design/etk_datapath.sv
// accumulators, label memory and output register of the tokenizer
// depends on etk_pkg
`timescale 1ns / 1ps
module etk_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [20:0]      s_ch,
    input  etk_pkg::cmd_t    cmd,
    output etk_pkg::stat_t   stat,
    output logic [4:0]       m_kind,
    output logic [20:0]      m_char_code,
    output logic [31:0]      m_int_value,
    output logic [59:0]      m_frac_digits,
    output logic [4:0]       m_frac_count,
    output logic [15:0]      m_exponent,
    output logic             m_overflow,
    output logic             m_last
);
    import etk_pkg::*;

    logic [20:0] ch_reg;
    logic [20:0] mem [MaxLabelChars];
    logic [20:0] rd_reg;
    logic [LenW-1:0] len_reg, len_next, rp_reg, rp_next;
    logic [31:0] int_reg, int_next;
    logic [59:0] frac_reg, frac_next;
    logic [4:0]  fcnt_reg, fcnt_next;
    logic [15:0] exp_reg, exp_next;
    logic        ov_reg, ov_next;
    logic [4:0]  kw_reg, kw_next;
    logic [3:0]  dig;
    logic [19:0] exp_wide;
    logic        wr;
    logic [IdxW-1:0] wa;
    logic [20:0] wd;

    assign dig = ch_reg[3:0] - 4'd0;
    assign stat.digit = (ch_reg >= 21'h30) && (ch_reg <= 21'h39);
    assign stat.alpha = ((ch_reg >= 21'h61) && (ch_reg <= 21'h7A))
                     || ((ch_reg >= 21'h41) && (ch_reg <= 21'h5A));
    assign stat.dot   = ch_reg == 21'h2E;
    assign stat.e     = (ch_reg == 21'h65) || (ch_reg == 21'h45);
    assign stat.star  = ch_reg == 21'h2A;
    assign stat.slash = ch_reg == 21'h2F;
    assign stat.zero  = ch_reg == 21'h0;
    assign stat.skip  = (ch_reg == 21'h20) || (ch_reg == 21'h0D);
    assign stat.keyword = (len_reg == LenW'(5)) && !ov_reg && (kw_reg == 5'b11111);
    assign stat.label_done = (rp_reg + LenW'(1)) >= len_reg;

    always_comb begin
        len_next = len_reg; int_next = int_reg; frac_next = frac_reg;
        fcnt_next = fcnt_reg; exp_next = exp_reg; ov_next = ov_reg; kw_next = kw_reg;
        exp_wide = 20'(exp_reg) * 20'd10 + 20'(dig);
        wr = 1'b0; wa = '0; wd = ch_reg;
        if (cmd.clear) begin
            len_next = '0; int_next = '0; frac_next = '0; fcnt_next = '0;
            exp_next = '0; ov_next = 1'b0; kw_next = '0;
        end
        if (cmd.absorb) begin
            unique case (cmd.mode)
                M_LABEL: begin
                    if (len_reg < LenW'(MaxLabelChars)) begin
                        wr = 1'b1; wa = len_reg[IdxW-1:0];
                        len_next = len_reg + LenW'(1);
                        unique case (len_reg)
                            LenW'(1): kw_next[1] = ch_reg == 21'h72;
                            LenW'(2): kw_next[2] = ch_reg == 21'h61;
                            LenW'(3): kw_next[3] = ch_reg == 21'h6D;
                            LenW'(4): kw_next[4] = ch_reg == 21'h65;
                            default: ;
                        endcase
                    end else ov_next = 1'b1;
                end
                M_INT: int_next = int_reg * 32'd10 + 32'(dig);
                M_FRAC: begin
                    if (fcnt_reg < 5'(MaxFracDigits)) begin
                        frac_next = frac_reg * 60'd10 + 60'(dig);
                        fcnt_next = fcnt_reg + 5'd1;
                    end else ov_next = 1'b1;
                end
                M_EXP: begin
                    if (exp_wide > 20'(ExpMax)) begin
                        exp_next = ExpMax; ov_next = 1'b1;
                    end else exp_next = exp_wide[15:0];
                end
                default: ;
            endcase
        end
        if (cmd.start) begin
            len_next = '0; int_next = '0; frac_next = '0; fcnt_next = '0;
            exp_next = '0; ov_next = 1'b0; kw_next = '0;
            if (stat.alpha) begin
                wr = 1'b1; wa = '0; len_next = LenW'(1);
                kw_next[0] = ch_reg == 21'h66;
            end else if (stat.digit) int_next = 32'(dig);
        end
    end

    always_comb begin
        rp_next = rp_reg;
        if (cmd.lbl_first) rp_next = '0;
        else if (cmd.lbl_step) rp_next = rp_reg + LenW'(1);
    end

    always_ff @(posedge aclk) begin
        if (wr) mem[wa] <= wd;
        rd_reg <= mem[rp_next[IdxW-1:0]];
        if (cmd.take) ch_reg <= s_ch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0; int_reg <= '0; frac_reg <= '0; fcnt_reg <= '0;
            exp_reg <= '0; ov_reg <= 1'b0; kw_reg <= '0; rp_reg <= '0;
        end else begin
            len_reg <= len_next; int_reg <= int_next; frac_reg <= frac_next;
            fcnt_reg <= fcnt_next; exp_reg <= exp_next; ov_reg <= ov_next;
            kw_reg <= kw_next; rp_reg <= rp_next;
        end
    end

    // output register, loaded before accumulators change
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_kind <= cmd.kind;
            m_last <= cmd.last;
            m_char_code <= cmd.use_char ? ch_reg : (cmd.use_lbl ? rd_reg : '0);
            m_int_value <= cmd.use_acc ? int_reg : '0;
            m_frac_digits <= (cmd.use_acc && cmd.kind == K_REAL) ? frac_reg : '0;
            m_frac_count <= (cmd.use_acc && cmd.kind == K_REAL) ? fcnt_reg : '0;
            m_exponent <= (cmd.use_acc && cmd.kind == K_REAL) ? exp_reg : '0;
            m_overflow <= ((cmd.use_acc && cmd.kind == K_REAL) || cmd.use_lbl)
                          ? ov_reg : 1'b0;
        end
    end
endmodule

### design/etk_ctrl.sv
// controller state machine of the tokenizer
// depends on etk_pkg
`timescale 1ns / 1ps
module etk_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  etk_pkg::stat_t  stat,
    output etk_pkg::cmd_t   cmd
);
    import etk_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   mv_reg, mv_next;
    logic   lbl_reg, lbl_next;   // emitting label chars
    logic   slot;
    kind_t  tk;
    logic   tail_emits;

    assign m_valid = mv_reg;
    assign slot = !mv_reg || m_ready;
    assign s_ready = (state_reg == S_IN) && !mv_reg;

    always_comb begin
        tk = single_kind(21'(0));
        tail_emits = 1'b0;
        if (stat.zero) tk = K_END;
        else if (!(stat.alpha || stat.digit || stat.star || stat.slash || stat.skip))
            tail_emits = 1'b1;
        if (stat.zero) tail_emits = 1'b1;
    end

    always_comb begin
        cmd = '0;
        cmd.mode = mode_reg;
        state_next = state_reg;
        mode_next = mode_reg;
        mv_next = mv_reg && !m_ready;
        lbl_next = lbl_reg;
        unique case (state_reg)
            S_IN: begin
                if (s_valid && s_ready) begin
                    cmd.take = 1'b1;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // decide whether the held char extends the pending token
                unique case (mode_reg)
                    M_LABEL: if (stat.alpha || stat.digit) begin
                        cmd.absorb = 1'b1; state_next = S_IN;
                    end
                    M_INT: if (stat.digit) begin
                        cmd.absorb = 1'b1; state_next = S_IN;
                    end else if (stat.dot) begin
                        mode_next = M_FRAC; state_next = S_IN;
                    end else if (stat.e) begin
                        mode_next = M_EXP; state_next = S_IN;
                    end
                    M_FRAC: if (stat.digit) begin
                        cmd.absorb = 1'b1; state_next = S_IN;
                    end else if (stat.e) begin
                        mode_next = M_EXP; state_next = S_IN;
                    end
                    M_EXP: if (stat.digit) begin
                        cmd.absorb = 1'b1; state_next = S_IN;
                    end
                    default: ;
                endcase
                if (state_next == S_FLUSH && slot) begin
                    priority if (mode_reg == M_STAR && stat.star) begin
                        cmd.load_out = 1'b1; cmd.kind = K_POW; cmd.last = 1'b1;
                        mv_next = 1'b1; cmd.clear = 1'b1; mode_next = M_IDLE;
                        state_next = S_IN;
                    end else if (mode_reg == M_SLASH && stat.slash) begin
                        cmd.load_out = 1'b1; cmd.kind = K_PARA; cmd.last = 1'b1;
                        mv_next = 1'b1; cmd.clear = 1'b1; mode_next = M_IDLE;
                        state_next = S_IN;
                    end else if (mode_reg == M_LABEL && !stat.keyword) begin
                        if (!lbl_reg) begin
                            cmd.lbl_first = 1'b1; lbl_next = 1'b1; // prime read
                        end else begin
                            cmd.load_out = 1'b1; cmd.kind = K_LCHAR; cmd.use_lbl = 1'b1;
                            cmd.last = stat.label_done && !tail_emits;
                            cmd.lbl_step = 1'b1; mv_next = 1'b1;
                            if (stat.label_done) begin
                                lbl_next = 1'b0; mode_next = M_IDLE;
                                state_next = S_TAIL;
                            end
                        end
                    end else if (mode_reg == M_IDLE) begin
                        state_next = S_TAIL;
                    end else begin
                        cmd.load_out = 1'b1; mv_next = 1'b1; cmd.use_acc = 1'b1;
                        cmd.last = !tail_emits;
                        unique case (mode_reg)
                            M_LABEL: cmd.kind = K_FRAME;
                            M_INT: cmd.kind = K_INT;
                            M_FRAC, M_EXP: cmd.kind = K_REAL;
                            M_STAR: cmd.kind = K_MUL;
                            default: cmd.kind = K_DIV;
                        endcase
                        mode_next = M_IDLE; state_next = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (slot) begin
                    if (tail_emits) begin
                        cmd.load_out = 1'b1; mv_next = 1'b1; cmd.last = 1'b1;
                        cmd.kind = tk;
                        cmd.clear = 1'b1;
                        mode_next = M_IDLE;
                        state_next = S_OUT;
                    end else begin
                        cmd.start = 1'b1;
                        priority if (stat.alpha) mode_next = M_LABEL;
                        else if (stat.digit) mode_next = M_INT;
                        else if (stat.star) mode_next = M_STAR;
                        else if (stat.slash) mode_next = M_SLASH;
                        else mode_next = M_IDLE;
                        state_next = S_IN;
                    end
                end
            end
            S_OUT: begin
                state_next = S_IN;
            end
            default: state_next = S_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IN; mode_reg <= M_IDLE; mv_reg <= 1'b0; lbl_reg <= 1'b0;
        end else begin
            state_reg <= state_next; mode_reg <= mode_next;
            mv_reg <= mv_next; lbl_reg <= lbl_next;
        end
    end
endmodule

### design/etk_kindsel.sv
// classifies a held character into its single-character token kind
// depends on etk_pkg
`timescale 1ns / 1ps
module etk_kindsel (
    input  logic [20:0]    ch,
    input  etk_pkg::cmd_t  cmd_in,
    output etk_pkg::cmd_t  cmd_out
);
    import etk_pkg::*;
    always_comb begin
        cmd_out = cmd_in;
        if (cmd_in.load_out && cmd_in.kind == K_UNK) begin
            cmd_out.kind = single_kind(ch);
            cmd_out.use_char = cmd_out.kind == K_UNK;
        end
    end
endmodule

### design/etk_checker.sv
// port-level checker for the expression tokenizer, bound to the top level
// depends on etk_pkg and expression_tokenizer_core_macros.svh
`timescale 1ns / 1ps
`include "expression_tokenizer_core_macros.svh"
module etk_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_kind,
    input logic       m_last
);
    import etk_pkg::*;
    `ETK_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind))
    `ETK_ASSERT_IMPL(a_kind, aclk, aresetn, m_valid, m_kind <= K_END)
    `ETK_ASSERT_IMPL(a_end_last, aclk, aresetn, m_valid && m_kind == K_END, m_last)
    `ETK_ASSERT_IMPL(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
endmodule

bind expression_tokenizer_core etk_checker u_chk (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_kind, .m_last
);

### tb/tb_expression_tokenizer_core.sv
// testbench for expression_tokenizer_core: directed and random character streams
// depends on etk_pkg and the expression_tokenizer_core rtl
`timescale 1ns / 1ps
module tb_expression_tokenizer_core;
    import etk_pkg::*;

    // one expected token
    typedef struct {
        logic [4:0]  kind;
        logic [20:0] char_code;
        logic [31:0] int_value;
        logic [59:0] frac_digits;
        logic [4:0]  frac_count;
        logic [15:0] exponent;
        logic        overflow;
        logic        last;
    } token_t;

    localparam int CycleLimit = 1000000;
    localparam int DrainCycles = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [20:0] s_ch = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_kind;
    logic [20:0] m_char_code;
    logic [31:0] m_int_value;
    logic [59:0] m_frac_digits;
    logic [4:0]  m_frac_count;
    logic [15:0] m_exponent;
    logic        m_overflow;
    logic        m_last;

    expression_tokenizer_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_ch(s_ch),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_char_code(m_char_code), .m_int_value(m_int_value),
        .m_frac_digits(m_frac_digits), .m_frac_count(m_frac_count),
        .m_exponent(m_exponent), .m_overflow(m_overflow), .m_last(m_last)
    );

    always #5 aclk = ~aclk;

    // scanner state mirrored from the block's behavior
    mode_t       lex_mode;
    logic [20:0] lbl_buf [MaxLabelChars];
    int          lbl_len;
    logic [31:0] int_acc;
    logic [59:0] frac_acc;
    int          frac_cnt;
    logic [31:0] exp_acc;
    logic        ovf_seen;

    token_t      token_queue[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_enable = 1'b1;
    int          hold_cycles = 0;   // long receiver hold-off, counted down in its own process
    int          stall_left = 0;    // rest of a short receiver idle burst

    function automatic bit is_digit_ch(logic [20:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha_ch(logic [20:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic token_t mk_token(kind_t k, logic [20:0] code = '0);
        token_t t;
        t = '{kind: k, char_code: code, int_value: '0, frac_digits: '0,
              frac_count: '0, exponent: '0, overflow: 1'b0, last: 1'b0};
        return t;
    endfunction

    function automatic void clear_scan();
        lex_mode = M_IDLE;
        lbl_len  = 0;
        int_acc  = '0;
        frac_acc = '0;
        frac_cnt = 0;
        exp_acc  = '0;
        ovf_seen = 1'b0;
    endfunction

    // emit whatever token is pending, then return to idle
    function automatic void flush_pending(ref token_t outs[$]);
        token_t t;
        bit     kw;
        case (lex_mode)
            M_LABEL: begin
                kw = (lbl_len == 5) && !ovf_seen && lbl_buf[0] == "f" && lbl_buf[1] == "r"
                     && lbl_buf[2] == "a" && lbl_buf[3] == "m" && lbl_buf[4] == "e";
                if (kw) begin
                    outs.push_back(mk_token(K_FRAME));
                end else begin
                    for (int i = 0; i < lbl_len; i++) begin
                        t = mk_token(K_LCHAR, lbl_buf[i]);
                        t.overflow = ovf_seen;
                        outs.push_back(t);
                    end
                end
            end
            M_INT: begin
                t = mk_token(K_INT);
                t.int_value = int_acc;
                outs.push_back(t);
            end
            M_FRAC, M_EXP: begin
                t = mk_token(K_REAL);
                t.int_value = int_acc;
                t.frac_digits = frac_acc;
                t.frac_count = frac_cnt[4:0];
                t.exponent = exp_acc[15:0];
                t.overflow = ovf_seen;
                outs.push_back(t);
            end
            M_STAR:  outs.push_back(mk_token(K_MUL));
            M_SLASH: outs.push_back(mk_token(K_DIV));
            default: ;
        endcase
        clear_scan();
    endfunction

    // tokens that one character completes
    function automatic void tokenize_char(logic [20:0] c);
        token_t outs[$];
        bit     handled = 1'b0;
        logic [31:0] v;
        case (lex_mode)
            M_LABEL: if (is_alpha_ch(c) || is_digit_ch(c)) begin
                if (lbl_len < MaxLabelChars) begin
                    lbl_buf[lbl_len] = c;
                    lbl_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
                return;
            end
            M_INT: begin
                if (is_digit_ch(c)) begin
                    int_acc = int_acc * 10 + (c - "0");
                    return;
                end
                if (c == ".") begin lex_mode = M_FRAC; return; end
                if (c == "e" || c == "E") begin lex_mode = M_EXP; return; end
            end
            M_FRAC: begin
                if (is_digit_ch(c)) begin
                    if (frac_cnt < MaxFracDigits) begin
                        frac_acc = frac_acc * 10 + (c - "0");
                        frac_cnt++;
                    end else begin
                        ovf_seen = 1'b1;
                    end
                    return;
                end
                if (c == "e" || c == "E") begin lex_mode = M_EXP; return; end
            end
            M_EXP: if (is_digit_ch(c)) begin
                v = exp_acc * 10 + (c - "0");
                if (v > 32'd65535) begin
                    v = 32'd65535;
                    ovf_seen = 1'b1;
                end
                exp_acc = v;
                return;
            end
            M_STAR: if (c == "*") begin
                clear_scan();
                outs.push_back(mk_token(K_POW));
                handled = 1'b1;
            end
            M_SLASH: if (c == "/") begin
                clear_scan();
                outs.push_back(mk_token(K_PARA));
                handled = 1'b1;
            end
            default: ;
        endcase
        if (!handled) begin
            flush_pending(outs);
            if (c == 0) begin
                outs.push_back(mk_token(K_END));
                clear_scan();
            end else if (is_alpha_ch(c)) begin
                lex_mode = M_LABEL;
                lbl_buf[0] = c;
                lbl_len = 1;
            end else if (is_digit_ch(c)) begin
                lex_mode = M_INT;
                int_acc = c - "0";
            end else if (c == "*") begin
                lex_mode = M_STAR;
            end else if (c == "/") begin
                lex_mode = M_SLASH;
            end else if (c == " " || c == 21'h0D) begin
                // skipped
            end else if (single_kind(c) == K_UNK) begin
                outs.push_back(mk_token(K_UNK, c));
            end else begin
                outs.push_back(mk_token(single_kind(c)));
            end
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) token_queue.push_back(outs[i]);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // send one character; random idle burst ahead of it
    task automatic send_char(logic [20:0] c);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tokenize_char(c);
    endtask

    task automatic send_text(string txt);
        foreach (txt[i]) send_char(21'(txt[i]));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (token_queue.size() != 0) @(posedge aclk);
    endtask

    // receiver stalls in bursts, or holds off for a long stretch
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker, field by field against the oldest expectation
    always @(posedge aclk) begin
        token_t e;
        if (aresetn && m_valid && m_ready) begin
            if (token_queue.size() == 0) begin
                report_mismatch("unexpected token", m_kind, 0);
            end else begin
                e = token_queue.pop_front();
                if (m_kind !== e.kind) report_mismatch("kind", m_kind, e.kind);
                if (m_char_code !== e.char_code)
                    report_mismatch("char_code", m_char_code, e.char_code);
                if (m_int_value !== e.int_value)
                    report_mismatch("int_value", m_int_value, e.int_value);
                if (m_frac_digits !== e.frac_digits)
                    report_mismatch("frac_digits", m_frac_digits, e.frac_digits);
                if (m_frac_count !== e.frac_count)
                    report_mismatch("frac_count", m_frac_count, e.frac_count);
                if (m_exponent !== e.exponent)
                    report_mismatch("exponent", m_exponent, e.exponent);
                if (m_overflow !== e.overflow)
                    report_mismatch("overflow", m_overflow, e.overflow);
                if (m_last !== e.last) report_mismatch("last", m_last, e.last);
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        if (cycle_count > CycleLimit) begin
            $display("expression_tokenizer_core verification failed");
            $finish;
        end
    end

    // operators, lookahead and every single-character kind
    task automatic test_operators();
        send_text("= + - * ** / // ( ) { } . ; ");
        send_char(21'h0A);
        send_char(21'h0D);
        send_text("*/");
        send_char(21'h0);
    endtask

    // number forms, wrap, long fraction, large exponent
    task automatic test_numbers();
        send_text("4294967299 1.5 2e3 7.25E12 3. 9e.1.");
        send_text("0.1234567890123456789012 5e99999;");
        send_char(21'h0);
    endtask

    // keyword, plain labels, long label and wide codes
    task automatic test_labels();
        send_text("frame frames fram Zz9 ");
        send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ+");
        send_char(21'h1FFFFF);
        send_char(21'h10FFFF);
        send_char(21'h7F);
        send_char(21'h0);
    endtask

    // receiver holds off while the sender waits on s_ready, then sender pauses for a drain
    task automatic test_backpressure();
        hold_cycles <= 300;
        send_text("alpha12beta*gamma+delta3 4.5e6 frame//x ");
        send_char(21'h0);
        wait_drained();
    endtask

    function automatic logic [20:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 21'($urandom_range("a", "z"));
        if (r < 40) return 21'($urandom_range("A", "Z"));
        if (r < 65) return 21'($urandom_range("0", "9"));
        if (r < 88) begin
            case ($urandom_range(0, 14))
                0: return 21'("=");  1: return 21'("+");  2: return 21'("-");
                3: return 21'("*");  4: return 21'("/");  5: return 21'(".");
                6: return 21'(";");  7: return 21'("(");  8: return 21'(")");
                9: return 21'("{");  10: return 21'("}"); 11: return 21'(" ");
                12: return 21'("e"); 13: return 21'h0A;
                default: return 21'h0D;
            endcase
        end
        if (r < 92) return 21'h0;
        if (r < 96) return 21'($urandom_range(21'h80, 21'h1FFFFF));
        return 21'($urandom());
    endfunction

    // random text streams, mostly well formed tokens
    task automatic test_random(int count, bit idle);
        idle_enable = idle;
        repeat (count) send_char(rand_char());
        send_char(21'h0);
    endtask

    initial begin
        clear_scan();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operators();
        test_numbers();
        test_labels();
        test_backpressure();
        test_random(10, 1'b1);
        test_random(6, 1'b0);
        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0 && token_queue.size() == 0) begin
            $display("expression_tokenizer_core verification clean");
        end else begin
            $display("expression_tokenizer_core verification failed");
        end
        $finish;
    end
endmodule
